@@ rtl/core/rsve_pkg.sv @@
// Package for the ribbon strip vertex expander: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package rsve_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned WIDTH_W = 31;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [30:0] half_width;
		logic signed [31:0] tex_u;
		logic [31:0] point_colour;
		logic chain_end;
	} point_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic [31:0] vert_colour;
		logic signed [31:0] vert_u;
		logic vert_v;
		logic strip_done;
	} vertex_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;     // capture the accepted point
		logic start_held;  // start offset job for the held point
		logic start_last;  // start offset job for the newly taken last point
		logic step;        // release the finished job back to idle
		logic emit_plus;   // select plus vertex
		logic done_flag;   // mark strip_done on plus vertex
		logic commit;      // shift window after the held point's pair
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic job_done;
		logic in_last;
		logic [1:0] seen;
	} dp_stat_t;

endpackage

@@ rtl/core/rsve_stream_if.sv @@
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing; payload type given by parameter.
`timescale 1ns / 1ps
interface rsve_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rsve_datapath.sv @@
// Datapath: point window, shared iterative offset unit (mul, sqrt, div), vertex mux.
// Depends on rsve_pkg.
`timescale 1ns / 1ps
module rsve_datapath (
	input  logic clk,
	input  logic arst_n,
	input  rsve_pkg::point_t in_pt,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  rsve_pkg::dp_cmd_t cmd,
	output rsve_pkg::dp_stat_t stat,
	output rsve_pkg::vertex_t vert
);

	typedef enum logic [9:0] {
		J_IDLE  = 10'b0000000001,
		J_SHR   = 10'b0000000010,
		J_MUL   = 10'b0000000100,
		J_CRS   = 10'b0000001000,
		J_NRM   = 10'b0000010000,
		J_SQ    = 10'b0000100000,
		J_SQRT  = 10'b0001000000,
		J_DIV   = 10'b0010000000,
		J_VTX   = 10'b0100000000,
		J_DONE  = 10'b1000000000
	} job_t;

	job_t jst_q;

	logic signed [31:0] ox_q, oy_q, oz_q, hx_q, hy_q, hz_q;
	logic [30:0] hw_q;
	logic signed [31:0] hu_q;
	logic [31:0] hc_q;
	logic [1:0] seen_q;
	rsve_pkg::point_t in_q;

	// job operands
	logic signed [31:0] px_q, py_q, pz_q;
	logic [30:0] w_q;
	logic signed [32:0] t_q [3];
	logic signed [32:0] e_q [3];
	logic signed [61:0] pr_q [6];
	logic signed [61:0] c_q [3];
	logic [61:0] m_q [3];
	logic [61:0] sum_q;
	logic [1:0] k_q;
	logic [63:0] rem_q, root_q, bit_q;
	logic [31:0] len_q;
	logic [62:0] num_q;
	logic [31:0] quo_q;
	logic [30:0] dr_q;
	logic [5:0] cnt_q;
	logic signed [32:0] off_q [3];
	logic signed [31:0] vm_q [3], vp_q [3];

	// shrink helper: smallest shift bringing max magnitude below 2^30
	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic signed [32:0] shr_mag(input logic signed [32:0] v,
	                                              input logic [1:0] s);
		logic [32:0] m;
		m = mag33(v) >> s;
		shr_mag = v[32] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [1:0] shr_amt(input logic [32:0] mx);
		shr_amt = mx[32] ? 2'd3 : mx[31] ? 2'd2 : mx[30] ? 2'd1 : 2'd0;
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [33:0] v);
		if (v > 34'sd2147483647) sat = 32'sh7fffffff;
		else if (v < -34'sd2147483648) sat = 32'sh80000000;
		else sat = v[31:0];
	endfunction

	logic [32:0] mt, me;
	logic [61:0] top;
	logic [5:0] lz;
	logic [63:0] sq_try;
	logic [32:0] div_trial;
	logic div_fit;
	logic [31:0] div_quo;

	always_comb begin
		mt = mag33(t_q[0]);
		if (mag33(t_q[1]) > mt) mt = mag33(t_q[1]);
		if (mag33(t_q[2]) > mt) mt = mag33(t_q[2]);
		me = mag33(e_q[0]);
		if (mag33(e_q[1]) > me) me = mag33(e_q[1]);
		if (mag33(e_q[2]) > me) me = mag33(e_q[2]);
		top = m_q[0] | m_q[1] | m_q[2];
		lz = '0;
		for (int i = 0; i < 62; i++) if (top[i]) lz = 6'(i);
		sq_try = root_q + bit_q;
		// restoring divide step: next dividend bit into the partial remainder
		div_trial = {1'b0, dr_q, num_q[62]};
		div_fit = (div_trial >= {1'b0, len_q});
		div_quo = {quo_q[30:0], div_fit};
	end

	logic signed [31:0] src_x, src_y, src_z;
	always_comb begin
		src_x = cmd.start_last ? in_q.point_x : hx_q;
		src_y = cmd.start_last ? in_q.point_y : hy_q;
		src_z = cmd.start_last ? in_q.point_z : hz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jst_q <= J_IDLE;
			seen_q <= '0;
		end else begin
			if (cmd.load_in && seen_q == 2'd0) seen_q <= in_pt.chain_end ? 2'd0 : 2'd1;
			if (cmd.commit) seen_q <= in_q.chain_end ? 2'd0 : 2'd2;
			unique case (jst_q)
				J_IDLE: if (cmd.start_held || cmd.start_last) jst_q <= J_SHR;
				J_SHR:  jst_q <= J_MUL;
				J_MUL:  jst_q <= J_CRS;
				J_CRS:  jst_q <= J_NRM;
				J_NRM:  jst_q <= (top == '0) ? J_VTX : J_SQ;
				J_SQ:   if (k_q == 2'd2) jst_q <= J_SQRT;
				J_SQRT: if (bit_q == '0) jst_q <= J_DIV;
				J_DIV:  if (cnt_q == 6'd0 && k_q == 2'd2) jst_q <= J_VTX;
				J_VTX:  jst_q <= J_DONE;
				J_DONE: if (cmd.step) jst_q <= J_IDLE;
				default: jst_q <= J_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_pt;
			if (seen_q == 2'd0) begin
				hx_q <= in_pt.point_x; hy_q <= in_pt.point_y; hz_q <= in_pt.point_z;
				hw_q <= in_pt.half_width; hu_q <= in_pt.tex_u; hc_q <= in_pt.point_colour;
			end
		end
		if (cmd.commit) begin
			ox_q <= hx_q; oy_q <= hy_q; oz_q <= hz_q;
			hx_q <= in_q.point_x; hy_q <= in_q.point_y; hz_q <= in_q.point_z;
			hw_q <= in_q.half_width; hu_q <= in_q.tex_u; hc_q <= in_q.point_colour;
		end
		unique case (jst_q)
			J_IDLE: if (cmd.start_held || cmd.start_last) begin
				px_q <= src_x; py_q <= src_y; pz_q <= src_z;
				w_q <= cmd.start_last ? in_q.half_width : hw_q;
				if (cmd.start_last) begin
					t_q[0] <= 33'(in_q.point_x) - 33'(ox_q);
					t_q[1] <= 33'(in_q.point_y) - 33'(oy_q);
					t_q[2] <= 33'(in_q.point_z) - 33'(oz_q);
				end else begin
					t_q[0] <= 33'(in_q.point_x) - 33'(seen_q == 2'd1 ? hx_q : ox_q);
					t_q[1] <= 33'(in_q.point_y) - 33'(seen_q == 2'd1 ? hy_q : oy_q);
					t_q[2] <= 33'(in_q.point_z) - 33'(seen_q == 2'd1 ? hz_q : oz_q);
				end
				e_q[0] <= 33'(eye_x) - 33'(src_x);
				e_q[1] <= 33'(eye_y) - 33'(src_y);
				e_q[2] <= 33'(eye_z) - 33'(src_z);
			end
			J_SHR: for (int i = 0; i < 3; i++) begin
				t_q[i] <= shr_mag(t_q[i], shr_amt(mt));
				e_q[i] <= shr_mag(e_q[i], shr_amt(me));
			end
			J_MUL: begin
				pr_q[0] <= 62'(t_q[1] * e_q[2]); pr_q[1] <= 62'(t_q[2] * e_q[1]);
				pr_q[2] <= 62'(t_q[2] * e_q[0]); pr_q[3] <= 62'(t_q[0] * e_q[2]);
				pr_q[4] <= 62'(t_q[0] * e_q[1]); pr_q[5] <= 62'(t_q[1] * e_q[0]);
			end
			J_CRS: for (int i = 0; i < 3; i++) begin
				c_q[i] <= pr_q[2*i] - pr_q[2*i+1];
				m_q[i] <= (pr_q[2*i] - pr_q[2*i+1]) < 0 ?
					62'(-(pr_q[2*i] - pr_q[2*i+1])) : 62'(pr_q[2*i] - pr_q[2*i+1]);
			end
			J_NRM: begin
				for (int i = 0; i < 3; i++)
					m_q[i] <= (lz >= 6'd29) ? (m_q[i] >> (lz - 6'd29))
					                        : (m_q[i] << (6'd29 - lz));
				sum_q <= '0; k_q <= '0;
				for (int i = 0; i < 3; i++) off_q[i] <= '0;
			end
			J_SQ: begin
				sum_q <= sum_q + m_q[k_q][29:0] * m_q[k_q][29:0];
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				if (k_q == 2'd2) begin
					rem_q <= 64'(sum_q + m_q[2][29:0] * m_q[2][29:0]);
					root_q <= '0; bit_q <= 64'd1 << 62;
				end
			end
			J_SQRT: begin
				if (bit_q != '0) begin
					if (rem_q >= sq_try) begin
						rem_q <= rem_q - sq_try; root_q <= (root_q >> 1) + bit_q;
					end else root_q <= root_q >> 1;
					bit_q <= bit_q >> 2;
				end else begin
					len_q <= root_q[31:0];
					k_q <= '0; cnt_q <= 6'd62;
					num_q <= 63'(m_q[0][29:0]) * 63'(w_q);
					quo_q <= '0; dr_q <= '0;
				end
			end
			J_DIV: begin
				// restoring divide, one quotient bit a cycle, for each component in turn
				if (cnt_q == 6'd0) begin
					off_q[k_q] <= c_q[k_q][61] ? -$signed({1'b0, div_quo})
					                           : $signed({1'b0, div_quo});
					if (k_q != 2'd2) begin
						k_q <= k_q + 2'd1; cnt_q <= 6'd62;
						num_q <= 63'(m_q[k_q + 2'd1][29:0]) * 63'(w_q);
						quo_q <= '0; dr_q <= '0;
					end
				end else begin
					cnt_q <= cnt_q - 6'd1;
					num_q <= num_q << 1;
					dr_q <= div_fit ? 31'(div_trial - {1'b0, len_q}) : div_trial[30:0];
					quo_q <= div_quo;
				end
			end
			J_VTX: begin
				vm_q[0] <= sat(34'(px_q) - 34'(off_q[0]));
				vm_q[1] <= sat(34'(py_q) - 34'(off_q[1]));
				vm_q[2] <= sat(34'(pz_q) - 34'(off_q[2]));
				vp_q[0] <= sat(34'(px_q) + 34'(off_q[0]));
				vp_q[1] <= sat(34'(py_q) + 34'(off_q[1]));
				vp_q[2] <= sat(34'(pz_q) + 34'(off_q[2]));
			end
			default: ;
		endcase
	end

	// vertex out: held point data before commit, new point after (last pair)
	always_comb begin
		vert.vert_x = cmd.emit_plus ? vp_q[0] : vm_q[0];
		vert.vert_y = cmd.emit_plus ? vp_q[1] : vm_q[1];
		vert.vert_z = cmd.emit_plus ? vp_q[2] : vm_q[2];
		vert.vert_colour = hc_q;
		vert.vert_u = hu_q;
		vert.vert_v = cmd.emit_plus;
		vert.strip_done = cmd.emit_plus & cmd.done_flag;
		stat.job_done = (jst_q == J_DONE);
		stat.in_last = in_q.chain_end;
		stat.seen = seen_q;
	end

endmodule

@@ rtl/core/rsve_ctrl.sv @@
// Controller: sequences accept, offset jobs and vertex beats.
// Depends on rsve_pkg.
`timescale 1ns / 1ps
module rsve_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  rsve_pkg::dp_stat_t stat,
	output rsve_pkg::dp_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_DEC   = 8'b00000010,
		S_JOB1  = 8'b00000100,
		S_M1    = 8'b00001000,
		S_P1    = 8'b00010000,
		S_JOB2  = 8'b00100000,
		S_M2    = 8'b01000000,
		S_P2    = 8'b10000000
	} state_t;

	state_t st_q;
	logic started_q;
	logic first_q;  // accepted point opened a new window

	always_comb begin
		cmd = '0;
		in_ready = (st_q == S_IDLE);
		out_valid = 1'b0;
		cmd.load_in = in_valid && in_ready;
		unique case (st_q)
			S_JOB1: begin
				cmd.start_held = !started_q;
				cmd.step = 1'b0;
			end
			S_M1: out_valid = 1'b1;
			S_P1: begin
				out_valid = 1'b1; cmd.emit_plus = 1'b1;
				cmd.commit = out_ready;
				cmd.step = out_ready;
			end
			S_JOB2: cmd.start_last = !started_q;
			S_M2: out_valid = 1'b1;
			S_P2: begin
				out_valid = 1'b1; cmd.emit_plus = 1'b1; cmd.done_flag = 1'b1;
				cmd.step = out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			started_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					first_q <= (stat.seen == 2'd0);
					st_q <= S_DEC;
				end
				S_DEC: begin
					started_q <= 1'b0;
					st_q <= first_q ? S_IDLE : S_JOB1;
				end
				S_JOB1: begin
					started_q <= 1'b1;
					if (started_q && stat.job_done) st_q <= S_M1;
				end
				S_M1: if (out_ready) st_q <= S_P1;
				S_P1: if (out_ready) begin
					started_q <= 1'b0;
					st_q <= stat.in_last ? S_JOB2 : S_IDLE;
				end
				S_JOB2: begin
					started_q <= 1'b1;
					if (started_q && stat.job_done) st_q <= S_M2;
				end
				S_M2: if (out_ready) st_q <= S_P2;
				S_P2: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/ribbon_strip_vertex_expander.sv @@
// Top level of the ribbon strip vertex expander: eye registers, controller, datapath.
// Depends on rsve_pkg, rsve_stream_if, rsve_ctrl, rsve_datapath.
`timescale 1ns / 1ps
// Camera-facing ribbon expander. Points arrive one beat at a time; output lags
// one point, two vertex beats per point, four on the chain's last point. A
// one-point chain emits nothing. Points are handled one at a time: a single
// shared offset unit (multiply, square root one result bit per cycle, restoring
// divide one quotient bit per cycle for each of three components) serves each
// vertex pair in turn. Eye registers are to be written through the plain write
// port only while the block is idle; the block itself does not enforce this.
module ribbon_strip_vertex_expander (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rsve_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	rsve_stream_if.sink   pt_in,
	rsve_stream_if.source vtx_out
);

	logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
	rsve_pkg::dp_cmd_t cmd;
	rsve_pkg::dp_stat_t stat;
	rsve_pkg::vertex_t vert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= '0; eye_y_q <= '0; eye_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsve_pkg::REG_EYE_X: eye_x_q <= cfg_data;
				rsve_pkg::REG_EYE_Y: eye_y_q <= cfg_data;
				rsve_pkg::REG_EYE_Z: eye_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rsve_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pt_in.valid), .in_ready(pt_in.ready),
		.out_valid(vtx_out.valid), .out_ready(vtx_out.ready),
		.stat(stat), .cmd(cmd)
	);

	rsve_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_pt(pt_in.data),
		.eye_x(eye_x_q), .eye_y(eye_y_q), .eye_z(eye_z_q),
		.cmd(cmd), .stat(stat), .vert(vert)
	);

	assign vtx_out.data = vert;

endmodule

@@ tb/ribbon_vertex_checker.sv @@
// Checker for the ribbon strip vertex expander: watches the point and vertex
// channels, predicts vertices and compares. Depends on rsve_pkg, rsve_stream_if.
`timescale 1ns / 1ps
module ribbon_vertex_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rsve_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic pt_valid,
	input logic pt_ready,
	input rsve_pkg::point_t pt_data,
	input logic vx_valid,
	input logic vx_ready,
	input rsve_pkg::vertex_t vx_data,
	output int fail_count,
	output int vertices_pending
);
	import rsve_pkg::*;

	longint eye [3];
	longint prev_pos [3];
	longint cur_pos [3];
	logic [30:0] cur_width;
	logic [31:0] cur_u;
	logic [31:0] cur_colour;
	int window_fill;
	vertex_t vertex_queue [$];

	assign vertices_pending = vertex_queue.size();

	function automatic longint abs64(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// shrink a vector so its largest magnitude is below 2^30, truncating to zero
	function automatic void narrow(inout longint v [3]);
		longint m [3];
		longint top;
		int s;
		s = 0;
		for (int k = 0; k < 3; k++) m[k] = abs64(v[k]);
		top = m[0] > m[1] ? m[0] : m[1];
		top = top > m[2] ? top : m[2];
		while ((top >> s) >= (64'sd1 << 30)) s++;
		for (int k = 0; k < 3; k++) v[k] = v[k] < 0 ? -(m[k] >> s) : (m[k] >> s);
	endfunction

	function automatic void enqueue_vertex(vertex_t vx);
		vertex_queue.insert(vertex_queue.size(), vx);
	endfunction

	function automatic void push_pair(longint p [3], longint a [3], longint b [3],
			logic [30:0] w, logic [31:0] u, logic [31:0] colour, logic done);
		longint t [3], e [3], c [3], off [3];
		longint m [3];
		longint top, len, sum;
		int s;
		vertex_t vx;
		for (int k = 0; k < 3; k++) begin
			t[k] = a[k] - b[k];
			e[k] = eye[k] - p[k];
		end
		narrow(t);
		narrow(e);
		c[0] = t[1] * e[2] - t[2] * e[1];
		c[1] = t[2] * e[0] - t[0] * e[2];
		c[2] = t[0] * e[1] - t[1] * e[0];
		for (int k = 0; k < 3; k++) m[k] = abs64(c[k]);
		top = m[0] > m[1] ? m[0] : m[1];
		top = top > m[2] ? top : m[2];
		if (top == 0) begin
			for (int k = 0; k < 3; k++) off[k] = 0;
		end else begin
			s = 0;
			if (top >= (64'sd1 << 30)) begin
				while ((top >> s) >= (64'sd1 << 30)) s++;
				for (int k = 0; k < 3; k++) m[k] = m[k] >> s;
			end else begin
				while ((top << s) < (64'sd1 << 29)) s++;
				for (int k = 0; k < 3; k++) m[k] = m[k] << s;
			end
			sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			len = int_sqrt(sum);
			for (int k = 0; k < 3; k++) begin
				off[k] = (m[k] * longint'({33'd0, w})) / len;
				if (c[k] < 0) off[k] = -off[k];
			end
		end
		vx.vert_colour = colour;
		vx.vert_u = u;
		vx.vert_x = 32'(clamp32(p[0] - off[0]));
		vx.vert_y = 32'(clamp32(p[1] - off[1]));
		vx.vert_z = 32'(clamp32(p[2] - off[2]));
		vx.vert_v = 1'b0;
		vx.strip_done = 1'b0;
		enqueue_vertex(vx);
		vx.vert_x = 32'(clamp32(p[0] + off[0]));
		vx.vert_y = 32'(clamp32(p[1] + off[1]));
		vx.vert_z = 32'(clamp32(p[2] + off[2]));
		vx.vert_v = 1'b1;
		vx.strip_done = done;
		enqueue_vertex(vx);
	endfunction

	function automatic void take_point(point_t pt);
		longint np [3];
		longint base [3];
		np[0] = pt.point_x;
		np[1] = pt.point_y;
		np[2] = pt.point_z;
		if (window_fill == 0) begin
			cur_pos = np;
			cur_width = pt.half_width;
			cur_u = pt.tex_u;
			cur_colour = pt.point_colour;
			window_fill = pt.chain_end ? 0 : 1;
			return;
		end
		// first point of a chain uses a one-sided tangent
		if (window_fill == 1) base = cur_pos;
		else base = prev_pos;
		push_pair(cur_pos, np, base, cur_width, cur_u, cur_colour, 1'b0);
		prev_pos = cur_pos;
		cur_pos = np;
		cur_width = pt.half_width;
		cur_u = pt.tex_u;
		cur_colour = pt.point_colour;
		window_fill = 2;
		if (pt.chain_end) begin
			push_pair(np, np, prev_pos, pt.half_width, pt.tex_u, pt.point_colour, 1'b1);
			window_fill = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				eye[k] = 0;
				prev_pos[k] = 0;
				cur_pos[k] = 0;
			end
			cur_width = '0;
			cur_u = '0;
			cur_colour = '0;
			window_fill = 0;
			fail_count = 0;
			vertex_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EYE_X: eye[0] = longint'(signed'(cfg_data));
					REG_EYE_Y: eye[1] = longint'(signed'(cfg_data));
					REG_EYE_Z: eye[2] = longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (vx_valid && vx_ready) begin
				if (vertex_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected vertex %h", vx_data);
				end else begin
					want = vertex_queue.pop_front();
					if (vx_data !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("vertex mismatch: exp %h got %h", want, vx_data);
					end
				end
			end
			if (pt_valid && pt_ready) take_point(pt_data);
		end
	end
endmodule

@@ tb/ribbon_strip_vertex_expander_tb.sv @@
// Testbench top for the ribbon strip vertex expander: clock, reset, eye
// writes, point stimulus and verdict. Depends on rsve_pkg, rsve_stream_if, checker.
`timescale 1ns / 1ps
module ribbon_strip_vertex_expander_tb;
	import rsve_pkg::*;

	localparam int DRAIN_CYCLES = 2000;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int fail_count;
	int vertices_pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off = 0;
	int cycle_count = 0;

	rsve_stream_if #(.payload_t(point_t)) pt_in ();
	rsve_stream_if #(.payload_t(vertex_t)) vtx_out ();

	ribbon_strip_vertex_expander uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pt_in(pt_in.sink),
		.vtx_out(vtx_out.source)
	);

	ribbon_vertex_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pt_valid(pt_in.valid),
		.pt_ready(pt_in.ready),
		.pt_data(pt_in.data),
		.vx_valid(vtx_out.valid),
		.vx_ready(vtx_out.ready),
		.vx_data(vtx_out.data),
		.fail_count(fail_count),
		.vertices_pending(vertices_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		pt_in.valid = 1'b0;
		pt_in.data = '0;
		vtx_out.ready = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off counted here
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			vtx_out.ready <= 1'b0;
		end else begin
			vtx_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ribbon_strip_vertex_expander_tb failed");
			$finish;
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return '0;
			3: return $urandom;
			default: return $urandom_range(32'h00200000) - 32'h00100000;
		endcase
	endfunction

	task automatic write_eye(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// valid stays up after a beat so back-to-back sends need no second drive
	task automatic send_point(input point_t pt);
		while ($urandom_range(99) < send_idle_pct) begin
			pt_in.valid <= 1'b0;
			@(posedge clk);
		end
		pt_in.valid <= 1'b1;
		pt_in.data <= pt;
		@(posedge clk);
		while (!pt_in.ready) @(posedge clk);
	endtask

	function automatic point_t make_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [30:0] w, input logic last);
		point_t pt;
		pt.point_x = x;
		pt.point_y = y;
		pt.point_z = z;
		pt.half_width = w;
		pt.tex_u = $urandom;
		pt.point_colour = $urandom;
		pt.chain_end = last;
		return pt;
	endfunction

	// settle between phases so eye writes see an idle block
	task automatic drain();
		pt_in.valid <= 1'b0;
		while (vertices_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_chains(input int n_points);
		int sent;
		int len;
		sent = 0;
		while (sent < n_points) begin
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2);
			for (int i = 0; i < len; i++) begin
				send_point(make_point(pick_coord(), pick_coord(), pick_coord(),
					($urandom_range(7) == 0) ? 31'h7fffffff
						: 31'($urandom_range(31'h000fffff)),
					i == len - 1));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset eye at origin
		send_idle_pct = 16;
		recv_idle_pct = 57;
		send_point(make_point(32'h00010000, 0, 0, 31'h00010000, 1'b1)); // lone point
		send_point(make_point(0, 0, 32'h00050000, 31'h00010000, 1'b0));
		send_point(make_point(32'h00010000, 0, 32'h00050000, 31'h00008000, 1'b1));
		// zero cross product: collinear with eye
		send_point(make_point(0, 0, 32'h00010000, 31'h00010000, 1'b0));
		send_point(make_point(0, 0, 32'h00020000, 31'h00010000, 1'b1));
		// extremes, saturation and repeated point
		send_point(make_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 1'b0));
		send_point(make_point(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b0));
		send_point(make_point(32'h80000000, 32'h7fffffff, 32'h80000000, 31'h0, 1'b0));
		send_point(make_point(32'hffffffff, 32'h00000001, 32'h00030000, 31'h1, 1'b1));
		drain();

		write_eye(REG_EYE_X, 32'h7fffffff);
		write_eye(REG_EYE_Y, 32'h80000000);
		write_eye(REG_EYE_Z, 32'h00100000);
		write_eye(2'd3, 32'h12345678); // unmapped index, ignored
		random_chains(60);

		// long receiver hold-off so the block backs up
		hold_off = 3000;
		random_chains(8);
		drain();

		send_idle_pct = 57;
		recv_idle_pct = 16;
		write_eye(REG_EYE_X, 32'h80000000);
		write_eye(REG_EYE_Y, 32'h7fffffff);
		write_eye(REG_EYE_Z, 32'h80000000);
		random_chains(50);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_eye(REG_EYE_X, $urandom);
		write_eye(REG_EYE_Y, $urandom);
		write_eye(REG_EYE_Z, $urandom);
		random_chains(40);
		drain();

		if (fail_count == 0) begin
			$display("ribbon_strip_vertex_expander_tb passed");
		end else begin
			$display("ribbon_strip_vertex_expander_tb failed");
		end
		$finish;
	end
endmodule
